FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and helpers for the Mandelbrot escape counter.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // Number format
    localparam int FRAC_BITS = 60;
    localparam int DW        = 64;
    localparam int ACC_W     = 2 * DW;
    localparam int CNT_W     = 16;
    localparam int HALF_W    = DW / 2;

    // |z|^2 escapes once any bit at or above 4 * 2^(2*FRAC_BITS) is set
    localparam int ESC_BIT   = 2 * FRAC_BITS + 2;

    localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(2500);

    // Point queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Partial products per complex step: three 64x64 products, four each
    localparam int PP_COUNT = 12;
    localparam int PP_W     = $clog2(PP_COUNT);

    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] c_imag;
        logic signed [DW-1:0] c_real;
    } point_t;

    typedef enum logic [1:0] {
        ACC_XX,
        ACC_YY,
        ACC_XY
    } acc_sel_t;

    typedef struct packed {
        acc_sel_t   dst;
        logic [1:0] shift;   // in units of 32 bits
    } mul_tag_t;

    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
        mul_tag_t          tag;
    } mul_req_t;

    typedef struct packed {
        logic            valid;
        logic [DW-1:0]   prod;
        mul_tag_t        tag;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_PREP,
        ENG_MUL,
        ENG_WAIT,
        ENG_CHECK,
        ENG_UPD,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        eng_state_t state;
        logic       busy;
    } eng_stat_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } front_stat_t;

    // Magnitude as unsigned; the most negative value maps to 2^63
    function automatic logic [DW-1:0] mag64(input logic signed [DW-1:0] v);
        logic [DW-1:0] r;
        r = v[DW-1] ? (DW'(0) - DW'(v)) : DW'(v);
        return r;
    endfunction

    // Narrow a wide signed value to 64 bits with saturation
    function automatic logic signed [DW-1:0] sat64(input logic signed [ACC_W-1:0] v);
        logic signed [DW-1:0] r;
        if (v[ACC_W-1:DW-1] == {(ACC_W-DW+1){v[ACC_W-1]}})
            r = v[DW-1:0];
        else if (v[ACC_W-1])
            r = SAT_MIN;
        else
            r = SAT_MAX;
        return r;
    endfunction

endpackage

FILE: rtl/core/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Input side: accepts points from the stream and holds them in a short
// queue until the iteration engine pulls them.
// ----------------------------------------------------------------------------
module mbe_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*mbe_pkg::DW-1:0]    s_tdata,    // c_real, c_imag
    output logic                        pt_valid,
    output mbe_pkg::point_t             pt,
    input  logic                        pt_pop,
    output mbe_pkg::front_stat_t        stat
);
    import mbe_pkg::*;

    point_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push;
    logic                pop;
    point_t              in_pt;

    // Unpack the item
    assign in_pt.c_real = s_tdata[DW-1:0];
    assign in_pt.c_imag = s_tdata[2*DW-1:DW];

    assign s_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = pt_pop && (cnt_reg != '0);

    assign pt_valid = (cnt_reg != '0);
    assign pt       = q_mem[rd_ptr_reg];

    assign stat.count = cnt_reg;
    assign stat.full  = !s_tready;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_pt;
    end

endmodule

FILE: rtl/core/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul
// Shared 32x32 unsigned multiplier with a registered product; the tag
// travels with the product to steer accumulation.
// ----------------------------------------------------------------------------
module mbe_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbe_pkg::mul_req_t  req,
    output mbe_pkg::mul_rsp_t  rsp
);
    import mbe_pkg::*;

    logic              valid_reg;
    logic [DW-1:0]     prod_reg;
    mul_tag_t          tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            prod_reg <= DW'(req.a) * DW'(req.b);
            tag_reg  <= req.tag;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.prod  = prod_reg;
    assign rsp.tag   = tag_reg;

endmodule

FILE: rtl/core/mbe_engine.sv
// ----------------------------------------------------------------------------
// mbe_engine
// Back end: iterates z = z*z + c for one point at a time. Each complex
// step forms |x|^2, |y|^2 and |x||y| from twelve 32x32 partial products,
// then tests for escape and updates z with floor shift and saturation.
// ----------------------------------------------------------------------------
module mbe_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mbe_pkg::CNT_W-1:0]   max_iterations,
    input  logic                        pt_valid,
    input  mbe_pkg::point_t             pt,
    output logic                        pt_pop,
    output mbe_pkg::mul_req_t           mul_req,
    input  mbe_pkg::mul_rsp_t           mul_rsp,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mbe_pkg::CNT_W-1:0]   m_tdata,    // iteration_count
    output mbe_pkg::eng_stat_t          stat
);
    import mbe_pkg::*;

    eng_state_t                 state_reg, state_next;
    logic [PP_W-1:0]            pp_reg, pp_next;
    logic                       res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]           res_reg, res_next;

    logic signed [DW-1:0]       x_reg, x_next;
    logic signed [DW-1:0]       y_reg, y_next;
    logic signed [DW-1:0]       cr_reg, cr_next;
    logic signed [DW-1:0]       ci_reg, ci_next;
    logic [DW-1:0]              mx_reg, mx_next;
    logic [DW-1:0]              my_reg, my_next;
    logic                       xy_neg_reg, xy_neg_next;
    logic [ACC_W-1:0]           xx_reg, xx_next;
    logic [ACC_W-1:0]           yy_reg, yy_next;
    logic [ACC_W-1:0]           xy_reg, xy_next;
    logic signed [ACC_W-1:0]    re_reg, re_next;
    logic signed [ACC_W-1:0]    im_reg, im_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    logic [ACC_W-1:0]           pp_add;
    logic [ACC_W-1:0]           mag;
    logic                       keep_going;
    logic [DW-1:0]              src_a;
    logic [DW-1:0]              src_b;
    acc_sel_t                   pp_dst;
    logic signed [ACC_W-1:0]    re_sum;
    logic signed [ACC_W-1:0]    im_sum;

    // Operand selection for the current partial product
    always_comb
    begin
        case (pp_reg[PP_W-1:2])
            2'd0:
            begin
                src_a  = mx_reg;
                src_b  = mx_reg;
                pp_dst = ACC_XX;
            end
            2'd1:
            begin
                src_a  = my_reg;
                src_b  = my_reg;
                pp_dst = ACC_YY;
            end
            default:
            begin
                src_a  = mx_reg;
                src_b  = my_reg;
                pp_dst = ACC_XY;
            end
        endcase
    end

    assign mul_req.valid     = (state_reg == ENG_MUL);
    assign mul_req.a         = pp_reg[1] ? src_a[DW-1:HALF_W] : src_a[HALF_W-1:0];
    assign mul_req.b         = pp_reg[0] ? src_b[DW-1:HALF_W] : src_b[HALF_W-1:0];
    assign mul_req.tag.dst   = pp_dst;
    assign mul_req.tag.shift = {1'b0, pp_reg[1]} + {1'b0, pp_reg[0]};

    // Partial product aligned to its weight
    assign pp_add = ACC_W'(mul_rsp.prod) << {mul_rsp.tag.shift, 5'b0};

    // Escape test and z update datapath
    assign mag        = xx_reg + yy_reg;
    assign keep_going = (count_reg < max_iterations) && (mag[ACC_W-1:ESC_BIT] == '0);
    assign re_sum     = (re_reg >>> FRAC_BITS) + ACC_W'(cr_reg);
    assign im_sum     = (im_reg >>> (FRAC_BITS - 1)) + ACC_W'(ci_reg);

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        pp_next        = pp_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        xy_neg_next    = xy_neg_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        count_next     = count_reg;
        pt_pop         = 1'b0;

        // Output register drains independently
        if (res_valid_reg && m_tready)
            res_valid_next = 1'b0;

        // Accumulate the product returned by the multiplier
        if (mul_rsp.valid)
        begin
            case (mul_rsp.tag.dst)
                ACC_XX:  xx_next = xx_reg + pp_add;
                ACC_YY:  yy_next = yy_reg + pp_add;
                ACC_XY:  xy_next = xy_reg + pp_add;
                default: xy_next = xy_reg;
            endcase
        end

        case (state_reg)
            ENG_IDLE:
            begin
                if (pt_valid)
                begin
                    pt_pop     = 1'b1;
                    x_next     = pt.c_real;
                    y_next     = pt.c_imag;
                    cr_next    = pt.c_real;
                    ci_next    = pt.c_imag;
                    count_next = CNT_W'(1);
                    state_next = ENG_PREP;
                end
            end
            ENG_PREP:
            begin
                mx_next     = mag64(x_reg);
                my_next     = mag64(y_reg);
                xy_neg_next = x_reg[DW-1] ^ y_reg[DW-1];
                xx_next     = '0;
                yy_next     = '0;
                xy_next     = '0;
                pp_next     = '0;
                state_next  = ENG_MUL;
            end
            ENG_MUL:
            begin
                if (pp_reg == PP_W'(PP_COUNT - 1))
                    state_next = ENG_WAIT;
                else
                    pp_next = pp_reg + 1'b1;
            end
            ENG_WAIT:
            begin
                state_next = ENG_CHECK;
            end
            ENG_CHECK:
            begin
                re_next = xx_reg - yy_reg;
                im_next = xy_neg_reg ? (ACC_W'(0) - xy_reg) : xy_reg;
                if (keep_going)
                    state_next = ENG_UPD;
                else
                    state_next = ENG_DONE;
            end
            ENG_UPD:
            begin
                x_next     = sat64(re_sum);
                y_next     = sat64(im_sum);
                count_next = count_reg + 1'b1;
                state_next = ENG_PREP;
            end
            ENG_DONE:
            begin
                if (!res_valid_reg || m_tready)
                begin
                    res_valid_next = 1'b1;
                    res_next       = count_reg;
                    state_next     = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            pp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pp_reg        <= pp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        xy_neg_reg <= xy_neg_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        xy_reg     <= xy_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        count_reg  <= count_next;
    end

    assign m_tvalid   = res_valid_reg;
    assign m_tdata    = res_reg;
    assign stat.state = state_reg;
    assign stat.busy  = (state_reg != ENG_IDLE);

endmodule

FILE: rtl/core/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Each complex step issues twelve partial products to the one shared 32x32
// multiplier. The engine works on one point at a time; the 2-entry queue
// can accept further points while the engine is busy.
// Reset (async, active low) empties the 2-entry queue, idles the engine, drops
// the output valid and sets max_iterations to 2500.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mandelbrot_escape_count
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*mbe_pkg::DW-1:0]    s_tdata,    // c_real [63:0], c_imag [127:64]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mbe_pkg::CNT_W-1:0]   m_tdata,    // iteration_count [15:0]
    input  logic                        cfg_we,
    input  logic [mbe_pkg::CNT_W-1:0]   cfg_wdata   // max_iterations
);
    import mbe_pkg::*;

    logic [CNT_W-1:0]   max_iter_reg;
    logic               pt_valid;
    point_t             pt;
    logic               pt_pop;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    eng_stat_t          eng_stat;
    front_stat_t        front_stat;

    // Iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_iter_reg <= MAX_ITER_RST;
        else if (cfg_we)
            max_iter_reg <= cfg_wdata;
    end

    mbe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_pop   (pt_pop),
        .stat     (front_stat)
    );

    mbe_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    mbe_engine u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (max_iter_reg),
        .pt_valid       (pt_valid),
        .pt             (pt),
        .pt_pop         (pt_pop),
        .mul_req        (mul_req),
        .mul_rsp        (mul_rsp),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .stat           (eng_stat)
    );

    // Checks
    `ASSERT_IMP(a_count_range, clk, rst_n, m_tvalid, (m_tdata != '0) && ((m_tdata <= max_iter_reg) || (m_tdata == CNT_W'(1))), "iteration count out of range")
    `ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, front_stat.count <= QCNT_W'(QDEPTH), "point queue overfilled")
    `ASSERT_IMP(a_full_at_depth, clk, rst_n, front_stat.full, front_stat.count == QCNT_W'(QDEPTH), "queue full below its depth")
    `ASSERT_NXT(a_accept_queued, clk, rst_n, s_tvalid && s_tready, front_stat.count != '0, "accepted item not queued")
    `ASSERT_IMP(a_mul_in_step, clk, rst_n, mul_rsp.valid, eng_stat.busy && ((eng_stat.state == ENG_MUL) || (eng_stat.state == ENG_WAIT)), "product arrived outside a multiply phase")

endmodule
